// File: rtl/tcce_pkg.sv
package tcce_pkg;

  localparam int DEF_MAX_CELLS = 16384;

  // Wide enough for any cursor target or screen size the block can produce.
  localparam int TGT_W = 17;
  localparam int CHAR_W = 8;
  localparam int COLOR_W = 24;
  localparam int CELL_W = CHAR_W + 2 * COLOR_W;
  localparam int DIM_W = 8;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_FG = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] RESET_BG = 24'h000000;
  localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_CHAR, RESET_FG, RESET_BG};
  localparam int TAB_STEP = 4;

  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_VT = 8'd11;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_FG = 2'd2;
  localparam logic [1:0] REG_BG = 2'd3;

  typedef enum logic [1:0] {
    REQ_PRINT  = 2'd0,
    REQ_SETPOS = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_GEOW, S_GEOM, S_COLW, S_PLACE, S_PDIV,
    S_PMUL, S_PFIX, S_COPYR, S_COPYW, S_BLANK, S_RD, S_RDW
  } state_e;

  typedef struct packed {
    logic              start;
    logic [TGT_W-1:0]  dividend;
    logic [DIM_W-1:0]  divisor;
  } div_req_t;

endpackage

// File: rtl/tcce_ram.sv
module tcce_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [Width-1:0]      wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [Width-1:0]      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/tcce_div.sv
module tcce_div import tcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [TGT_W-1:0]  quot_o,
  output logic [DIM_W-1:0]  rem_o
);
  localparam int CntW = $clog2(TGT_W);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [TGT_W-1:0]  dvd_q;
  logic [DIM_W-1:0]  rem_q;
  logic [DIM_W-1:0]  dvs_q;
  logic [DIM_W:0]    shifted;
  logic [DIM_W:0]    diff;
  logic              ge;

  // One quotient bit per cycle; the remainder always stays below the divisor.
  always_comb begin
    shifted = {rem_q, dvd_q[TGT_W-1]};
    ge = (shifted >= {1'b0, dvs_q});
    diff = shifted - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(TGT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TGT_W-2:0], ge};
      rem_q <= ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o = rem_q;

endmodule

// File: rtl/text_console_cell_engine.sv
// Channel   | Direction | Signals                                     | Handshake
// ----------+-----------+---------------------------------------------+------------------------
// request   | in        | req_type_i char_code_i advance_i position_i | start && !busy
// result    | out       | cell_* scroll_lines_o cleared_o cursor_*    | done_o, one-cycle beat
// config    | in        | cfg_index_i cfg_data_i                      | cfg_valid_i && cfg_ready_o
//
// One request is worked at a time; busy stays high until its result beat.
// A printable byte passes through cell write, placement and cursor cell read.
// Control bytes add a column divide; a scroll adds a divide, a multiply,
// a read and a write per copied cell and a write per blanked cell; a clear
// writes every screen cell. The cell memory has a single write port. After
// reset a clearing pass writes all MaxCells cells, then the screen geometry
// is derived. A write to columns or rows re-derives geometry and holds busy
// meanwhile. The result receiver cannot stall: each result is shown for one
// cycle.
module text_console_cell_engine import tcce_pkg::*; #(
  parameter int MaxCells = DEF_MAX_CELLS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic                advance_i,
  input  logic [15:0]         position_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [COLOR_W-1:0]  cfg_data_i,
  output logic                done_o,
  output logic                cell_written_o,
  output logic [13:0]         cell_index_o,
  output logic [CHAR_W-1:0]   cell_char_o,
  output logic [DIM_W-1:0]    scroll_lines_o,
  output logic                cleared_o,
  output logic [13:0]         cursor_pos_o,
  output logic [COLOR_W-1:0]  cursor_color_o
);
  localparam int AW = (MaxCells > 1) ? $clog2(MaxCells) : 1;
  localparam int KCW = TGT_W + DIM_W;

  state_e state_q, state_d;

  logic [DIM_W-1:0]   columns_q, columns_d, rows_q, rows_d;
  logic [COLOR_W-1:0] fg_q, fg_d, bg_q, bg_d;
  logic               geo_dirty_q, geo_dirty_d;
  logic [DIM_W-1:0]   c_q, c_d, r_q, r_d;
  logic [TGT_W-1:0]   total_q, total_d;

  logic [AW-1:0]      cursor_q, cursor_d;
  logic [TGT_W-1:0]   i_q, i_d, lim_q, lim_d, sc_q, sc_d, k_q, k_d;
  logic [TGT_W-1:0]   target_q, target_d;
  logic [KCW-1:0]     kc_q, kc_d;
  logic [CHAR_W-1:0]  ch_q, ch_d;

  logic               written_q, written_d, clr_q, clr_d;
  logic [AW-1:0]      widx_q, widx_d;
  logic [CHAR_W-1:0]  wchr_q, wchr_d;
  logic [DIM_W-1:0]   s_q, s_d;

  logic               done_q, done_d;
  logic               o_written_q, o_cleared_q;
  logic [13:0]        o_index_q, o_cursor_q;
  logic [CHAR_W-1:0]  o_char_q;
  logic [DIM_W-1:0]   o_scroll_q;
  logic [COLOR_W-1:0] o_color_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  div_req_t           div_req;
  logic               div_done;
  logic [TGT_W-1:0]   div_quot;
  logic [DIM_W-1:0]   div_rem;

  logic [DIM_W-1:0]   col0, c_eff, r0;
  logic [TGT_W-1:0]   kc_diff;
  logic [KCW-1:0]     kc_sub;
  logic               accept;
  logic               is_ctrl;

  tcce_ram #(
    .Width (CELL_W),
    .Depth (MaxCells)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE) || geo_dirty_q;
  assign cfg_ready_o = 1'b1;

  // Effective geometry: zero counts become one, columns capped at the store
  // size; the row cap comes from the store size divided by the columns.
  always_comb begin
    col0 = (columns_q == '0) ? DIM_W'(1) : columns_q;
    c_eff = (TGT_W'(col0) > TGT_W'(MaxCells)) ? DIM_W'(MaxCells) : col0;
    r0 = (rows_q == '0) ? DIM_W'(1) : rows_q;
    is_ctrl = (char_code_i == CH_TAB) || (char_code_i == CH_LF) ||
              (char_code_i == CH_VT) || (char_code_i == CH_CR);
    kc_sub = KCW'(target_q) - kc_q;
    kc_diff = total_q - sc_q;
  end

  always_comb begin
    state_d = state_q;
    columns_d = columns_q;
    rows_d = rows_q;
    fg_d = fg_q;
    bg_d = bg_q;
    geo_dirty_d = geo_dirty_q;
    c_d = c_q;
    r_d = r_q;
    total_d = total_q;
    cursor_d = cursor_q;
    i_d = i_q;
    lim_d = lim_q;
    sc_d = sc_q;
    k_d = k_q;
    kc_d = kc_q;
    target_d = target_q;
    ch_d = ch_q;
    written_d = written_q;
    clr_d = clr_q;
    widx_d = widx_q;
    wchr_d = wchr_q;
    s_d = s_q;
    done_d = 1'b0;
    ram_we = 1'b0;
    ram_waddr = i_q[AW-1:0];
    ram_wdata = BLANK_CELL;
    ram_raddr = cursor_q;
    div_req.start = 1'b0;
    div_req.dividend = TGT_W'(cursor_q);
    div_req.divisor = c_q;

    unique case (state_q)
      S_INIT: begin
        // Power-up pass that blanks every cell of the store.
        ram_we = 1'b1;
        if (i_q == TGT_W'(MaxCells - 1)) begin
          i_d = '0;
          state_d = S_IDLE;
        end else begin
          i_d = i_q + TGT_W'(1);
        end
      end
      S_IDLE: begin
        if (geo_dirty_q) begin
          div_req.start = 1'b1;
          div_req.dividend = TGT_W'(MaxCells);
          div_req.divisor = c_eff;
          c_d = c_eff;
          geo_dirty_d = 1'b0;
          state_d = S_GEOW;
        end else if (accept) begin
          ch_d = char_code_i;
          written_d = 1'b0;
          widx_d = '0;
          wchr_d = '0;
          clr_d = 1'b0;
          s_d = '0;
          unique case (req_e'(req_type_i))
            REQ_PRINT: begin
              if (is_ctrl) begin
                div_req.start = 1'b1;
                state_d = S_COLW;
              end else begin
                // A stale cursor beyond the screen stores nothing but still moves.
                if (TGT_W'(cursor_q) < total_q) begin
                  ram_we = 1'b1;
                  ram_waddr = cursor_q;
                  ram_wdata = {char_code_i, fg_q, bg_q};
                  written_d = 1'b1;
                  widx_d = cursor_q;
                  wchr_d = char_code_i;
                end
                target_d = TGT_W'(cursor_q) + TGT_W'(advance_i);
                state_d = S_PLACE;
              end
            end
            REQ_SETPOS: begin
              target_d = TGT_W'(position_i);
              state_d = S_PLACE;
            end
            REQ_CLEAR: begin
              clr_d = 1'b1;
              i_d = '0;
              state_d = S_BLANK;
            end
            REQ_NONE: begin
              state_d = S_RD;
            end
          endcase
        end
      end
      S_GEOW: begin
        if (div_done) begin
          r_d = (div_quot < TGT_W'(r0)) ? div_quot[DIM_W-1:0] : r0;
          state_d = S_GEOM;
        end
      end
      S_GEOM: begin
        total_d = TGT_W'(r_q) * TGT_W'(c_q);
        state_d = S_IDLE;
      end
      S_COLW: begin
        // The divider remainder is the cursor column.
        if (div_done) begin
          priority case (ch_q)
            CH_TAB: target_d = TGT_W'(cursor_q) + TGT_W'(TAB_STEP) - TGT_W'(div_rem[1:0]);
            CH_VT:  target_d = TGT_W'(cursor_q) + TGT_W'(c_q);
            CH_CR:  target_d = TGT_W'(cursor_q) - TGT_W'(div_rem);
            default: target_d = TGT_W'(cursor_q) - TGT_W'(div_rem) + TGT_W'(c_q);
          endcase
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        if (target_q < total_q) begin
          cursor_d = target_q[AW-1:0];
          state_d = S_RD;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = target_q - total_q;
          state_d = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_done) begin
          k_d = div_quot + TGT_W'(1);
          s_d = ((div_quot + TGT_W'(1)) < TGT_W'(r_q)) ? DIM_W'(div_quot + TGT_W'(1)) : r_q;
          state_d = S_PMUL;
        end
      end
      S_PMUL: begin
        kc_d = KCW'(k_q) * KCW'(c_q);
        sc_d = TGT_W'(s_q) * TGT_W'(c_q);
        state_d = S_PFIX;
      end
      S_PFIX: begin
        cursor_d = kc_sub[AW-1:0];
        lim_d = kc_diff;
        i_d = '0;
        state_d = (kc_diff == '0) ? S_BLANK : S_COPYR;
      end
      S_COPYR: begin
        ram_raddr = AW'(i_q + sc_q);
        state_d = S_COPYW;
      end
      S_COPYW: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
        i_d = i_q + TGT_W'(1);
        state_d = ((i_q + TGT_W'(1)) == lim_q) ? S_BLANK : S_COPYR;
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (i_q == total_q - TGT_W'(1)) begin
          state_d = S_RD;
        end else begin
          i_d = i_q + TGT_W'(1);
        end
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COLUMNS: begin
          columns_d = cfg_data_i[DIM_W-1:0];
          geo_dirty_d = 1'b1;
        end
        REG_ROWS: begin
          rows_d = cfg_data_i[DIM_W-1:0];
          geo_dirty_d = 1'b1;
        end
        REG_FG: fg_d = cfg_data_i;
        REG_BG: bg_d = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      columns_q <= DIM_W'(80);
      rows_q <= DIM_W'(25);
      fg_q <= RESET_FG;
      bg_q <= RESET_BG;
      geo_dirty_q <= 1'b1;
      c_q <= DIM_W'(1);
      r_q <= DIM_W'(1);
      total_q <= TGT_W'(1);
      cursor_q <= '0;
      i_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      columns_q <= columns_d;
      rows_q <= rows_d;
      fg_q <= fg_d;
      bg_q <= bg_d;
      geo_dirty_q <= geo_dirty_d;
      c_q <= c_d;
      r_q <= r_d;
      total_q <= total_d;
      cursor_q <= cursor_d;
      i_q <= i_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
    sc_q <= sc_d;
    k_q <= k_d;
    kc_q <= kc_d;
    target_q <= target_d;
    ch_q <= ch_d;
    written_q <= written_d;
    clr_q <= clr_d;
    widx_q <= widx_d;
    wchr_q <= wchr_d;
    s_q <= s_d;
    if (state_q == S_RDW) begin
      o_written_q <= written_q;
      o_index_q <= 14'(widx_q);
      o_char_q <= wchr_q;
      o_scroll_q <= s_q;
      o_cleared_q <= clr_q;
      o_cursor_q <= 14'(cursor_q);
      o_color_q <= ram_rdata[CELL_W-CHAR_W-1:COLOR_W];
    end
  end

  assign done_o = done_q;
  assign cell_written_o = o_written_q;
  assign cell_index_o = o_index_q;
  assign cell_char_o = o_char_q;
  assign scroll_lines_o = o_scroll_q;
  assign cleared_o = o_cleared_q;
  assign cursor_pos_o = o_cursor_q;
  assign cursor_color_o = o_color_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("busy not raised after an accepted request");
  a_done_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_RDW)) else $error("result beat without cursor read");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result beat lasted more than one cycle");
  a_copy_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPYW) |-> (i_q < lim_q)) else $error("scroll copy past its limit");

endmodule

// File: dv/tb_text_console_cell_engine.sv
module tb_text_console_cell_engine;
  import tcce_pkg::*;

  localparam int NCELLS = DEF_MAX_CELLS;
  // Cycles without any beat before the run is declared hung. The slowest
  // single request is a scroll on the largest screen, and the clearing pass
  // after reset writes all NCELLS cells.
  localparam int HANG_LIMIT = 200000;

  // One result beat as the block should present it.
  typedef struct {
    logic              written;
    logic [13:0]       index;
    logic [CHAR_W-1:0] chr;
    logic [DIM_W-1:0]  scrolled;
    logic              cleared;
    logic [13:0]       cursor;
    logic [COLOR_W-1:0] color;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = REQ_PRINT;
  logic [CHAR_W-1:0] char_code = '0;
  logic advance = 1'b0;
  logic [15:0] position = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_COLUMNS;
  logic [COLOR_W-1:0] cfg_data = '0;
  logic done;
  logic cell_written;
  logic [13:0] cell_index;
  logic [CHAR_W-1:0] cell_char;
  logic [DIM_W-1:0] scroll_lines;
  logic cleared;
  logic [13:0] cursor_pos;
  logic [COLOR_W-1:0] cursor_color;

  text_console_cell_engine dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .req_type_i(req_type), .char_code_i(char_code), .advance_i(advance),
    .position_i(position), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .done_o(done),
    .cell_written_o(cell_written), .cell_index_o(cell_index),
    .cell_char_o(cell_char), .scroll_lines_o(scroll_lines), .cleared_o(cleared),
    .cursor_pos_o(cursor_pos), .cursor_color_o(cursor_color)
  );

  // Clock with period 4.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the console: characters and foregrounds of every cell. The
  // background is written but never observable on the result ports, so it
  // is not tracked.
  logic [CHAR_W-1:0]  shadow_chr [NCELLS];
  logic [COLOR_W-1:0] shadow_fg [NCELLS];
  int unsigned shadow_cursor;
  int unsigned cfg_columns, cfg_rows;
  logic [COLOR_W-1:0] cfg_fg, cfg_bg;

  cell_result_t pending_results[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int scroll_count = 0;
  int clear_count = 0;
  int idle_cycles = 0;

  // Screen width actually used: zero counts as one column.
  function automatic int unsigned screen_cols();
    return (cfg_columns == 0) ? 1 : cfg_columns;
  endfunction

  // Screen height actually used: zero counts as one row, and the screen
  // never holds more cells than the store.
  function automatic int unsigned screen_rows();
    int unsigned r;
    r = (cfg_rows == 0) ? 1 : cfg_rows;
    if (r > NCELLS / screen_cols()) r = NCELLS / screen_cols();
    return r;
  endfunction

  function automatic void blank_shadow(int unsigned i);
    if (i < NCELLS) begin
      shadow_chr[i] = BLANK_CHAR;
      shadow_fg[i] = RESET_FG;
    end
  endfunction

  // Moves the cursor to the target. Overflow past the last cell scrolls the
  // screen up by whole rows; the copy covers rows minus the scrolled rows,
  // and the vacated bottom rows turn blank in the reset colors.
  function automatic int unsigned move_cursor(int unsigned target);
    int unsigned c, r, total, k, s;
    c = screen_cols();
    r = screen_rows();
    total = c * r;
    if (target < total) begin
      shadow_cursor = target;
      return 0;
    end
    k = (target - total) / c + 1;
    shadow_cursor = target - k * c;
    s = (k < r) ? k : r;
    for (int unsigned i = 0; i + s * c < total; i++) begin
      shadow_chr[i] = shadow_chr[i + s * c];
      shadow_fg[i] = shadow_fg[i + s * c];
    end
    for (int unsigned i = total - s * c; i < total; i++) blank_shadow(i);
    return s;
  endfunction

  // Works out the result of one accepted request and updates the shadow.
  function automatic cell_result_t console_step(logic [1:0] req, logic [7:0] ch,
                                                logic adv, logic [15:0] pos);
    cell_result_t res;
    int unsigned c, total, col, s;
    c = screen_cols();
    total = c * screen_rows();
    s = 0;
    res.written = 1'b0;
    res.index = '0;
    res.chr = '0;
    res.cleared = 1'b0;
    if (req == REQ_PRINT) begin
      col = shadow_cursor % c;
      if (ch == CH_TAB) begin
        s = move_cursor(shadow_cursor + TAB_STEP - (col % TAB_STEP));
      end else if (ch == CH_VT) begin
        s = move_cursor(shadow_cursor + c);
      end else if (ch == CH_CR) begin
        s = move_cursor(shadow_cursor - col);
      end else if (ch == CH_LF) begin
        s = move_cursor(shadow_cursor - col + c);
      end else begin
        // A cursor left beyond the screen by a geometry change stores
        // nothing, but the cursor still moves.
        if (shadow_cursor < total) begin
          shadow_chr[shadow_cursor] = ch;
          shadow_fg[shadow_cursor] = cfg_fg;
          res.written = 1'b1;
          res.index = shadow_cursor[13:0];
          res.chr = ch;
        end
        s = move_cursor(shadow_cursor + 32'(adv));
      end
    end else if (req == REQ_SETPOS) begin
      s = move_cursor(32'(pos));
    end else if (req == REQ_CLEAR) begin
      for (int unsigned i = 0; i < total; i++) blank_shadow(i);
      res.cleared = 1'b1;
    end
    res.scrolled = s[7:0];
    res.cursor = shadow_cursor[13:0];
    res.color = (shadow_cursor < NCELLS) ? shadow_fg[shadow_cursor] : '0;
    return res;
  endfunction

  // Sends one request beat. The caller sits at a falling edge, and so does
  // this task on return; start stays high when the next beat follows at once.
  task automatic send_request(logic [1:0] req, logic [7:0] ch, logic adv,
                              logic [15:0] pos);
    int gap;
    gap = $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    char_code <= ch;
    advance <= adv;
    position <= pos;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(console_step(req, ch, adv, pos));
    beats_in++;
    @(negedge clk);
  endtask

  // Waits until every result is in and the block has settled.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register over the configuration channel; no request is outstanding then.
  task automatic write_reg(logic [1:0] idx, logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_COLUMNS: cfg_columns = 32'(data[7:0]);
      REG_ROWS:    cfg_rows = 32'(data[7:0]);
      REG_FG:      cfg_fg = data;
      default:     cfg_bg = data;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(int unsigned cols, int unsigned rows);
    drain();
    write_reg(REG_COLUMNS, COLOR_W'(cols));
    write_reg(REG_ROWS, COLOR_W'(rows));
  endtask

  // Result checker: every done beat is matched against the oldest prediction.
  always @(posedge clk) begin
    cell_result_t exp_res;
    if (rst_n && done) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.scrolled != 0) scroll_count++;
        if (exp_res.cleared) clear_count++;
        if (cell_written !== exp_res.written) begin
          $error("cell_written: expected %0d, got %0d", exp_res.written, cell_written);
          errors++;
        end
        if (cell_index !== exp_res.index) begin
          $error("cell_index: expected %0d, got %0d", exp_res.index, cell_index);
          errors++;
        end
        if (cell_char !== exp_res.chr) begin
          $error("cell_char: expected %0h, got %0h", exp_res.chr, cell_char);
          errors++;
        end
        if (scroll_lines !== exp_res.scrolled) begin
          $error("scroll_lines: expected %0d, got %0d", exp_res.scrolled, scroll_lines);
          errors++;
        end
        if (cleared !== exp_res.cleared) begin
          $error("cleared: expected %0d, got %0d", exp_res.cleared, cleared);
          errors++;
        end
        if (cursor_pos !== exp_res.cursor) begin
          $error("cursor_pos: expected %0d, got %0d", exp_res.cursor, cursor_pos);
          errors++;
        end
        if (cursor_color !== exp_res.color) begin
          $error("cursor_color: expected %0h, got %0h", exp_res.color, cursor_color);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("tb_text_console_cell_engine: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Printing, cursor advance, a held cursor and the byte extremes on the
  // reset geometry of 80 by 25.
  task automatic test_print_basics();
    send_request(REQ_PRINT, 8'h41, 1'b1, '0);
    send_request(REQ_PRINT, 8'h00, 1'b1, '0);
    send_request(REQ_PRINT, 8'hFF, 1'b0, '0);
    send_request(REQ_PRINT, 8'hFF, 1'b1, 16'hFFFF);
  endtask

  // Tab, vertical tab, carriage return and newline, including a newline
  // from the last row that scrolls.
  task automatic test_control_codes();
    send_request(REQ_PRINT, CH_TAB, 1'b0, '0);
    send_request(REQ_PRINT, CH_TAB, 1'b1, '0);
    send_request(REQ_PRINT, CH_VT, 1'b0, '0);
    send_request(REQ_PRINT, CH_CR, 1'b0, '0);
    send_request(REQ_PRINT, CH_LF, 1'b0, '0);
    send_request(REQ_SETPOS, '0, 1'b0, 16'd1999);
    send_request(REQ_PRINT, 8'h7A, 1'b1, '0);
    send_request(REQ_SETPOS, '0, 1'b0, 16'd1990);
    send_request(REQ_PRINT, CH_LF, 1'b0, '0);
  endtask

  // Set-cursor into the second row past the end and beyond the whole screen,
  // a print, a clear and the unused request type.
  task automatic test_setpos_clear();
    send_request(REQ_SETPOS, '0, 1'b0, 16'd2085);
    send_request(REQ_SETPOS, '0, 1'b0, 16'hFFFF);
    send_request(REQ_PRINT, 8'h55, 1'b0, '0);
    send_request(REQ_CLEAR, 8'hAA, 1'b1, 16'h5555);
    send_request(REQ_NONE, 8'h33, 1'b1, 16'hAAAA);
  endtask

  // Geometry extremes: a cursor left stale by a shrink, zero sizes, one by
  // one, and the widest screen whose rows are clamped to the store.
  task automatic test_geometry_extremes();
    send_request(REQ_SETPOS, '0, 1'b0, 16'd1500);
    set_geometry(4, 4);
    write_reg(REG_FG, 24'h123456);
    write_reg(REG_BG, 24'hFEDCBA);
    send_request(REQ_PRINT, 8'h42, 1'b1, '0);
    send_request(REQ_PRINT, 8'h43, 1'b1, '0);
    set_geometry(0, 0);
    send_request(REQ_PRINT, 8'h44, 1'b1, '0);
    send_request(REQ_PRINT, CH_TAB, 1'b0, '0);
    set_geometry(255, 255);
    send_request(REQ_SETPOS, '0, 1'b0, 16'd16319);
    send_request(REQ_PRINT, 8'h45, 1'b1, '0);
    send_request(REQ_CLEAR, '0, 1'b0, '0);
  endtask

  // Random phases: each phase picks a geometry and colors, then mixes
  // printable text with control bytes, cursor moves, clears and the unused
  // type. Small screens keep scrolls cheap; a few phases use large ones.
  task automatic test_random();
    int unsigned cols, rows, pick, nitems;
    logic [7:0] ch;
    logic [15:0] pos;
    for (int phase = 0; phase < 36; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        cols = $urandom_range(0, 1) ? 255 : 0;
        rows = $urandom_range(0, 1) ? 255 : 0;
      end else if (pick == 1) begin
        cols = $urandom_range(40, 255);
        rows = $urandom_range(10, 255);
      end else begin
        cols = $urandom_range(1, 20);
        rows = $urandom_range(1, 10);
      end
      set_geometry(cols, rows);
      write_reg(REG_FG, COLOR_W'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_BG, COLOR_W'($urandom_range(0, 24'hFFFFFF)));
      nitems = (pick == 1 || (cols == 255 && rows == 255)) ? 6 : 28;
      for (int n = 0; n < nitems; n++) begin
        pick = $urandom_range(0, 99);
        ch = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: ch = CH_TAB;
            1: ch = CH_VT;
            2: ch = CH_CR;
            default: ch = CH_LF;
          endcase
        end
        pos = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 16'hFFFF))
                                       : 16'($urandom_range(0, cols * rows + 2 * cols));
        if (pick < 65) begin
          send_request(REQ_PRINT, ch, $urandom_range(0, 3) != 0, pos);
        end else if (pick < 88) begin
          send_request(REQ_SETPOS, ch, 1'($urandom_range(0, 1)), pos);
        end else if (pick < 95) begin
          send_request(REQ_CLEAR, ch, 1'($urandom_range(0, 1)), pos);
        end else begin
          send_request(REQ_NONE, ch, 1'($urandom_range(0, 1)), pos);
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NCELLS; i++) blank_shadow(i);
    shadow_cursor = 0;
    cfg_columns = 80;
    cfg_rows = 25;
    cfg_fg = RESET_FG;
    cfg_bg = RESET_BG;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_print_basics();
    test_control_codes();
    test_setpos_clear();
    test_geometry_extremes();
    test_random();
    drain();
    repeat (30) @(negedge clk);
    $display("Covered %0d requests and %0d result beats, with %0d scrolls and %0d clears",
             beats_in, beats_out, scroll_count, clear_count);
    $display("across directed edge cases and 36 random geometry and color phases.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_text_console_cell_engine: PASS");
    end else begin
      $display("tb_text_console_cell_engine: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_div.sv
rtl/text_console_cell_engine.sv
dv/tb_text_console_cell_engine.sv
